// ===== sv/icsd_pkg.sv =====
// Shared types, constants and key-matching functions for the combo sequence detector.
// Used by icsd_cfg, icsd_core and input_combo_sequence_detector_core.
`timescale 1ns / 1ps
`default_nettype none

package icsd_pkg;

  localparam int MAX_KEYS  = 4;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = 2;
  localparam int KEY_W     = 14;
  localparam int THR_W     = 12;

  localparam logic [15:0] HOLDOFF_RESET = 16'd500;
  localparam logic [TIME_BITS-1:0] TIME_START = TIME_BITS'(0) - TIME_BITS'(HOLDOFF_RESET);

  localparam logic [1:0] DEV_LIGHT   = 2'd0;
  localparam logic [1:0] DEV_BUTTON  = 2'd1;
  localparam logic [1:0] DEV_ENCODER = 2'd2;

  localparam logic [1:0] MOVE_LEFT  = 2'd1;
  localparam logic [1:0] MOVE_RIGHT = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SEQ_LEN   = 3'd0;
  localparam logic [2:0] REG_KEY0      = 3'd1;
  localparam logic [2:0] REG_KEY1      = 3'd2;
  localparam logic [2:0] REG_KEY2      = 3'd3;
  localparam logic [2:0] REG_KEY3      = 3'd4;
  localparam logic [2:0] REG_HOLDOFF   = 3'd5;
  localparam logic [2:0] REG_LIGHT_MIN = 3'd6;

  typedef struct packed {
    logic [2:0]                        sequence_length;
    logic [MAX_KEYS-1:0][KEY_W-1:0]    key_word;
    logic [15:0]                       holdoff_ms;
    logic [THR_W-1:0]                  light_minimum;
  } icsd_cfg_t;

  typedef struct packed {
    logic                 clear_status;
    logic                 button_press;
    logic [1:0]           encoder_move;
    logic [THR_W-1:0]     light_sample;
    logic [TIME_BITS-1:0] now_ms;
  } icsd_item_t;

  typedef struct packed {
    logic             combo_flag;
    logic [IDX_W-1:0] position;
    logic [1:0]       completions;
  } icsd_result_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } icsd_adv_t;

  function automatic logic key_hit(input logic [KEY_W-1:0] w, input logic [1:0] dev,
                                   input logic [THR_W-1:0] val);
    return (w[13:12] == dev) && (val >= w[THR_W-1:0]);
  endfunction

  // Index of the last active key: length clamped to 1..MAX_KEYS, minus one.
  function automatic logic [IDX_W-1:0] active_last(input logic [2:0] len);
    logic [IDX_W-1:0] r;
    if (len == 3'd0) begin
      r = '0;
    end else if (32'(len) > MAX_KEYS) begin
      r = IDX_W'(MAX_KEYS - 1);
    end else begin
      r = IDX_W'(len - 3'd1);
    end
    return r;
  endfunction

  // One event against the expected key; a miss retries once at the first key.
  function automatic icsd_adv_t key_step(input logic [IDX_W-1:0] idx,
                                         input logic [IDX_W-1:0] last,
                                         input logic [1:0] dev,
                                         input logic [THR_W-1:0] val,
                                         input logic [MAX_KEYS-1:0][KEY_W-1:0] keys);
    logic             hit;
    logic [IDX_W-1:0] i;
    icsd_adv_t        r;
    i   = idx;
    hit = key_hit(keys[i], dev, val);
    if (!hit) begin
      i   = '0;
      hit = key_hit(keys[0], dev, val);
    end
    r.done = 1'b0;
    r.idx  = i;
    if (hit) begin
      if (i >= last) begin
        r.done = 1'b1;
      end else begin
        r.idx = i + IDX_W'(1);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/icsd_cfg.sv =====
// APB-style configuration register file for the combo sequence detector.
// Depends on icsd_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module icsd_cfg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output icsd_pkg::icsd_cfg_t      cfg
);
  import icsd_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sequence_length <= 3'd3;
      cfg.key_word[0]     <= KEY_W'(8193);
      cfg.key_word[1]     <= KEY_W'(4096);
      cfg.key_word[2]     <= KEY_W'(8194);
      cfg.key_word[3]     <= KEY_W'(0);
      cfg.holdoff_ms      <= HOLDOFF_RESET;
      cfg.light_minimum   <= THR_W'(1000);
    end else if (wr) begin
      unique case (idx)
        REG_SEQ_LEN:   cfg.sequence_length <= pwdata[2:0];
        REG_KEY0:      cfg.key_word[0]     <= pwdata[KEY_W-1:0];
        REG_KEY1:      cfg.key_word[1]     <= pwdata[KEY_W-1:0];
        REG_KEY2:      cfg.key_word[2]     <= pwdata[KEY_W-1:0];
        REG_KEY3:      cfg.key_word[3]     <= pwdata[KEY_W-1:0];
        REG_HOLDOFF:   cfg.holdoff_ms      <= pwdata[15:0];
        REG_LIGHT_MIN: cfg.light_minimum   <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEQ_LEN:   prdata = {29'd0, cfg.sequence_length};
      REG_KEY0:      prdata = {18'd0, cfg.key_word[0]};
      REG_KEY1:      prdata = {18'd0, cfg.key_word[1]};
      REG_KEY2:      prdata = {18'd0, cfg.key_word[2]};
      REG_KEY3:      prdata = {18'd0, cfg.key_word[3]};
      REG_HOLDOFF:   prdata = {16'd0, cfg.holdoff_ms};
      REG_LIGHT_MIN: prdata = {20'd0, cfg.light_minimum};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/icsd_core.sv =====
// Detector state and the combinational step: hold-off checks and key matching.
// Depends on icsd_pkg for types and the key_step function.
`timescale 1ns / 1ps
`default_nettype none

module icsd_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire icsd_pkg::icsd_cfg_t  cfg,
  input  wire icsd_pkg::icsd_item_t item,
  output icsd_pkg::icsd_result_t    result
);
  import icsd_pkg::*;

  logic [TIME_BITS-1:0] light_last_time, light_last_time_next;
  logic [TIME_BITS-1:0] encoder_last_time, encoder_last_time_next;
  logic [TIME_BITS-1:0] button_last_time, button_last_time_next;
  logic [1:0]           pending_direction, pending_direction_next;
  logic                 pending_button, pending_button_next;
  logic [IDX_W-1:0]     key_index, key_index_next;
  logic                 sticky_done, sticky_done_next;

  logic [IDX_W-1:0]     last;
  logic [IDX_W-1:0]     idx0;
  logic [1:0]           dir;
  logic                 btn;
  logic                 light_ev, enc_ev, btn_ev;
  logic [TIME_BITS-1:0] holdoff;
  icsd_adv_t            a_light, a_enc, a_btn;
  logic [IDX_W-1:0]     i1, i2, i3;
  logic [1:0]           done;

  assign last    = active_last(cfg.sequence_length);
  assign holdoff = TIME_BITS'(cfg.holdoff_ms);

  always_comb begin
    idx0 = (key_index > last) ? '0 : key_index;
    dir  = (item.encoder_move == MOVE_LEFT || item.encoder_move == MOVE_RIGHT) ?
           item.encoder_move : pending_direction;
    btn  = pending_button | item.button_press;

    // wrapping elapsed-time checks, all three in parallel
    light_ev = ((item.now_ms - light_last_time) >= holdoff) &&
               (item.light_sample > cfg.light_minimum);
    enc_ev   = ((item.now_ms - encoder_last_time) >= holdoff) && (dir != 2'd0);
    btn_ev   = ((item.now_ms - button_last_time) >= holdoff) && btn;

    a_light = key_step(idx0, last, DEV_LIGHT, item.light_sample, cfg.key_word);
    i1      = light_ev ? a_light.idx : idx0;
    a_enc   = key_step(i1, last, DEV_ENCODER, {{(THR_W-2){1'b0}}, dir}, cfg.key_word);
    i2      = enc_ev ? a_enc.idx : i1;
    a_btn   = key_step(i2, last, DEV_BUTTON, '0, cfg.key_word);
    i3      = btn_ev ? a_btn.idx : i2;

    done = 2'({1'b0, light_ev & a_light.done} + {1'b0, enc_ev & a_enc.done}
              + {1'b0, btn_ev & a_btn.done});

    light_last_time_next   = light_ev ? item.now_ms : light_last_time;
    encoder_last_time_next = enc_ev ? item.now_ms : encoder_last_time;
    button_last_time_next  = btn_ev ? item.now_ms : button_last_time;
    pending_direction_next = enc_ev ? 2'd0 : dir;
    pending_button_next    = btn_ev ? 1'b0 : btn;
    key_index_next         = i3;

    result.completions = done;
    result.position    = i3;
    result.combo_flag  = sticky_done | (done != 2'd0);
    sticky_done_next   = result.combo_flag & ~item.clear_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_last_time   <= TIME_START;
      encoder_last_time <= TIME_START;
      button_last_time  <= TIME_START;
      pending_direction <= 2'd0;
      pending_button    <= 1'b0;
      key_index         <= '0;
      sticky_done       <= 1'b0;
    end else if (en) begin
      light_last_time   <= light_last_time_next;
      encoder_last_time <= encoder_last_time_next;
      button_last_time  <= button_last_time_next;
      pending_direction <= pending_direction_next;
      pending_button    <= pending_button_next;
      key_index         <= key_index_next;
      sticky_done       <= sticky_done_next;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    en |=> (key_index <= $past(last)))
    else $error("position beyond last active key");

  a_done_sets_flag: assert property (@(posedge clk) disable iff (rst)
    en && (done != 2'd0) && !item.clear_status |=> sticky_done)
    else $error("completion did not set sticky flag");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(key_index) && $stable(sticky_done) && $stable(pending_button))
    else $error("state changed without a request");

  a_pending_dir_valid: assert property (@(posedge clk) disable iff (rst)
    pending_direction != 2'd3)
    else $error("pending direction holds code three");

endmodule

`default_nettype wire

// ===== sv/input_combo_sequence_detector_core.sv =====
// Input combo sequence detector: one result per polling request.
//
// Channels: slave stream s_* carries a polling request (time stamp, light
// sample, encoder move, button press, clear); master stream m_* returns
// completions, key position and the sticky combo flag. Keys, sequence
// length, hold-off and light minimum sit in an APB register file; the user
// must write it only while no request is in flight; it is not checked.
// An accepted request is held in the input register, stepped
// combinationally in icsd_core and stored in the result register on m_*.
// Throughput: one request per cycle while m_* does not stall; the input
// register, the step in icsd_core and the output register move together.
// Reset: registers take their defaults, the three last-event times start at
// zero minus 500 ms, pending events, position and flag clear.
// Stall: while m_tready is low with a result held, the pipeline freezes;
// s_tready stays high only while the input register is empty.
// Depends on icsd_pkg, icsd_cfg and icsd_core.
`timescale 1ns / 1ps
`default_nettype none

module input_combo_sequence_detector_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] now_ms, [43:32] light_sample, [45:44] encoder_move,
  // [46] button_press, [47] clear_status
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] completions, [3:2] position, [4] combo_flag, [7:5] zero
  output logic      [7:0]  m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import icsd_pkg::*;

  icsd_cfg_t    cfg;
  icsd_item_t   item;
  icsd_result_t result;
  logic         item_valid;
  logic         adv;
  logic         step;

  icsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  icsd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (step),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  assign adv      = !m_tvalid || m_tready;
  assign step     = item_valid && adv;
  assign s_tready = !item_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_tready) begin
        item_valid <= s_tvalid;
      end
      if (adv) begin
        m_tvalid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.now_ms       <= s_tdata[31:0];
      item.light_sample <= s_tdata[43:32];
      item.encoder_move <= s_tdata[45:44];
      item.button_press <= s_tdata[46];
      item.clear_status <= s_tdata[47];
    end
    if (step) begin
      m_tdata <= {3'd0, result.combo_flag, result.position, result.completions};
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_input_combo_sequence_detector_core.sv =====
// Self-checking testbench for input_combo_sequence_detector_core: polling requests on s_*,
// one result per request on m_*, keys and timing set over APB. Needs icsd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_input_combo_sequence_detector_core;
  import icsd_pkg::*;

  localparam int          STALL_LIMIT    = 5000;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam logic [2:0]  REG_UNUSED     = 3'd7;
  localparam logic [1:0]  DEV_NONE       = 2'd3;
  localparam logic [1:0]  MOVE_NONE      = 2'd0;
  localparam logic [1:0]  MOVE_BAD       = 2'd3;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [31:0] now_ms, [43:32] light_sample, [45:44] encoder_move,
  // [46] button_press, [47] clear_status
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [1:0] completions, [3:2] position, [4] combo_flag, [7:5] zero
  logic [7:0]  m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  input_combo_sequence_detector_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic [2:0]       cfg_len       = 3'd3;
  logic [KEY_W-1:0] cfg_key [MAX_KEYS] = '{14'd8193, 14'd4096, 14'd8194, 14'd0};
  logic [15:0]      cfg_holdoff   = HOLDOFF_RESET;
  logic [THR_W-1:0] cfg_light_min = 12'd1000;

  // detector state as the predictor sees it
  logic [TIME_BITS-1:0] light_seen = TIME_START;
  logic [TIME_BITS-1:0] enc_seen   = TIME_START;
  logic [TIME_BITS-1:0] btn_seen   = TIME_START;
  logic [1:0]           pend_dir   = MOVE_NONE;
  logic                 pend_btn   = 1'b0;
  logic [IDX_W-1:0]     key_pos    = '0;
  logic                 combo_set  = 1'b0;

  icsd_result_t expected_q[$];
  int mismatches = 0, polls_sent = 0, results_seen = 0;
  int completions_seen = 0, reg_writes = 0, quiet_cycles = 0;
  int src_idle_pct = 0, snk_stall_pct = 0;
  logic [TIME_BITS-1:0] stamp = '0;
  logic rx_hold = 1'b0;
  event rx_hold_ev;

  function automatic logic [IDX_W-1:0] last_key();
    if (cfg_len == 3'd0) return '0;
    if (cfg_len > 3'(MAX_KEYS)) return IDX_W'(MAX_KEYS - 1);
    return IDX_W'(cfg_len - 3'd1);
  endfunction

  function automatic logic key_fits(input logic [1:0] dev, input logic [THR_W-1:0] val);
    return cfg_key[key_pos][13:12] == dev && val >= cfg_key[key_pos][THR_W-1:0];
  endfunction

  // a miss falls back to the first key and is tried there once more
  function automatic logic match_event(input logic [1:0] dev, input logic [THR_W-1:0] val);
    if (!key_fits(dev, val)) begin
      key_pos = '0;
      if (!key_fits(dev, val)) return 1'b0;
    end
    if (key_pos >= last_key()) begin
      combo_set = 1'b1;
      return 1'b1;
    end
    key_pos = key_pos + 1'b1;
    return 1'b0;
  endfunction

  function automatic logic holdoff_over(input logic [TIME_BITS-1:0] now,
                                        input logic [TIME_BITS-1:0] last);
    logic [TIME_BITS-1:0] diff;
    diff = now - last;
    return diff >= TIME_BITS'(cfg_holdoff);
  endfunction

  function automatic icsd_result_t predict_poll(input icsd_item_t it);
    icsd_result_t r;
    logic [1:0]   done;
    done = '0;
    if (key_pos > last_key()) key_pos = '0;
    if (it.encoder_move == MOVE_LEFT || it.encoder_move == MOVE_RIGHT)
      pend_dir = it.encoder_move;
    if (it.button_press) pend_btn = 1'b1;
    if (holdoff_over(it.now_ms, light_seen) && it.light_sample > cfg_light_min) begin
      done = done + match_event(DEV_LIGHT, it.light_sample);
      light_seen = it.now_ms;
    end
    if (holdoff_over(it.now_ms, enc_seen) && pend_dir != MOVE_NONE) begin
      done = done + match_event(DEV_ENCODER, THR_W'(pend_dir));
      pend_dir = MOVE_NONE;
      enc_seen = it.now_ms;
    end
    if (holdoff_over(it.now_ms, btn_seen) && pend_btn) begin
      done = done + match_event(DEV_BUTTON, '0);
      pend_btn = 1'b0;
      btn_seen = it.now_ms;
    end
    r.completions = done;
    r.position    = key_pos;
    r.combo_flag  = combo_set;
    if (it.clear_status) combo_set = 1'b0;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // request/result tracking and watchdog
  always @(posedge clk) begin
    icsd_result_t got, want, pred;
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (s_tvalid && s_tready) begin
        pred = predict_poll(icsd_item_t'(s_tdata));
        expected_q.insert(expected_q.size(), pred);
        polls_sent++;
        moved = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        results_seen++;
        got = icsd_result_t'(m_tdata[4:0]);
        completions_seen += got.completions;
        if (expected_q.size() == 0) begin
          note_mismatch($sformatf("result %h with no request outstanding", m_tdata));
        end else begin
          want = expected_q.pop_front();
          if (got.completions !== want.completions || got.position !== want.position ||
              got.combo_flag !== want.combo_flag || m_tdata[7:5] !== 3'b000)
            note_mismatch($sformatf(
              "result %0d: completions %0d/%0d position %0d/%0d flag %0d/%0d pad %b",
              results_seen, want.completions, got.completions, want.position,
              got.position, want.combo_flag, got.combo_flag, m_tdata[7:5]));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d cycles without a handshake, %0d results outstanding",
                 quiet_cycles, expected_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(rx_hold_ev);
      rx_hold = 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_poll(input icsd_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    case (idx) inside
      REG_SEQ_LEN:                        cfg_len = val[2:0];
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
        cfg_key[IDX_W'(idx - REG_KEY0)] = val[KEY_W-1:0];
      REG_HOLDOFF:                        cfg_holdoff = val[15:0];
      REG_LIGHT_MIN:                      cfg_light_min = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic icsd_item_t mk_poll(input logic [31:0] t, input logic [11:0] l,
                                         input logic [1:0] mv, input logic b, input logic c);
    icsd_item_t it;
    it.now_ms       = t;
    it.light_sample = l;
    it.encoder_move = mv;
    it.button_press = b;
    it.clear_status = c;
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [1:0]       dev;
    logic [THR_W-1:0] thr;
    case ($urandom_range(0, 9))
      0, 1, 2: begin dev = DEV_LIGHT;   thr = THR_W'($urandom_range(0, 4095)); end
      3, 4, 5: begin dev = DEV_ENCODER; thr = THR_W'($urandom_range(0, 3)); end
      6, 7, 8: begin
        dev = DEV_BUTTON;
        thr = ($urandom_range(0, 4) != 0) ? '0 : THR_W'($urandom_range(0, 4095));
      end
      default: begin dev = DEV_NONE;    thr = THR_W'($urandom_range(0, 4095)); end
    endcase
    return {dev, thr};
  endfunction

  // guided polls feed the expected key, mostly after the hold-off has elapsed; others are noise
  function automatic icsd_item_t next_poll(input logic guided);
    logic [KEY_W-1:0] w;
    logic [11:0]      light;
    logic [1:0]       mv;
    logic             press;
    int               lo;
    case ($urandom_range(0, 19))
      0:             stamp = $urandom;
      1, 2, 3, 4, 5: stamp = stamp + $urandom_range(0, cfg_holdoff);
      default:       stamp = stamp + cfg_holdoff + $urandom_range(0, 50);
    endcase
    if (!guided)
      return mk_poll(stamp, 12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
    w     = cfg_key[(key_pos > last_key()) ? '0 : key_pos];
    light = THR_W'($urandom_range(0, cfg_light_min));
    mv    = MOVE_NONE;
    press = 1'b0;
    case (w[13:12])
      DEV_LIGHT: begin
        lo = int'(cfg_light_min) + 1;
        if (int'(w[THR_W-1:0]) > lo) lo = int'(w[THR_W-1:0]);
        if (lo <= 4095) light = THR_W'($urandom_range(lo, 4095));
      end
      DEV_ENCODER: mv = (w[THR_W-1:0] <= 1 && $urandom_range(0, 1)) ? MOVE_LEFT : MOVE_RIGHT;
      DEV_BUTTON:  press = 1'b1;
      default: ;
    endcase
    return mk_poll(stamp, light, mv, press, $urandom_range(0, 9) == 0);
  endfunction

  task automatic cfg_randomize();
    int n;
    n = $urandom_range(0, 9);
    write_reg(REG_SEQ_LEN, (n < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7));
    write_reg(REG_KEY0, 32'(rand_key()));
    write_reg(REG_KEY1, 32'(rand_key()));
    write_reg(REG_KEY2, 32'(rand_key()));
    write_reg(REG_KEY3, 32'(rand_key()));
    case ($urandom_range(0, 5))
      0:       write_reg(REG_HOLDOFF, 0);
      1:       write_reg(REG_HOLDOFF, 32'hFFFF);
      default: write_reg(REG_HOLDOFF, $urandom_range(1, 1500));
    endcase
    case ($urandom_range(0, 5))
      0:       write_reg(REG_LIGHT_MIN, 0);
      1:       write_reg(REG_LIGHT_MIN, 32'hFFF);
      default: write_reg(REG_LIGHT_MIN, $urandom_range(0, 3000));
    endcase
  endtask

  // reset defaults: threshold edges, hold-off edges, pending events, wrap, clear
  task automatic test_reset_defaults();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_poll(mk_poll(32'd0, 12'd0, MOVE_NONE, 1'b0, 1'b0));
    send_poll(mk_poll(32'd0, 12'd1000, MOVE_RIGHT, 1'b0, 1'b0));
    send_poll(mk_poll(32'd1, 12'd4095, MOVE_NONE, 1'b1, 1'b0));
    send_poll(mk_poll(32'd499, 12'd0, MOVE_LEFT, 1'b0, 1'b0));
    send_poll(mk_poll(32'd499, 12'd0, MOVE_RIGHT, 1'b0, 1'b0));
    send_poll(mk_poll(32'd500, 12'd0, MOVE_BAD, 1'b0, 1'b0));
    send_poll(mk_poll(32'd1001, 12'd0, MOVE_NONE, 1'b1, 1'b0));
    send_poll(mk_poll(32'd1500, 12'd0, MOVE_RIGHT, 1'b0, 1'b0));
    send_poll(mk_poll(32'd1600, 12'd0, MOVE_NONE, 1'b0, 1'b1));
    send_poll(mk_poll(32'd1700, 12'd0, MOVE_NONE, 1'b0, 1'b0));
    send_poll(mk_poll(32'hFFFF_FF00, 12'd4095, MOVE_LEFT, 1'b1, 1'b0));
    send_poll(mk_poll(32'h0000_0100, 12'd1001, MOVE_RIGHT, 1'b1, 1'b0));
    send_poll(mk_poll(32'hFFFF_FFFF, 12'd4095, MOVE_RIGHT, 1'b1, 1'b1));
    send_poll(mk_poll(32'hAAAA_AAAA, 12'd2048, MOVE_LEFT, 1'b0, 1'b0));
    send_poll(mk_poll(32'h5555_5555, 12'd1365, MOVE_RIGHT, 1'b1, 1'b1));
    drain_results();
  endtask

  // length clamps, device code three, position past a shortened sequence,
  // hold-off and light minimum at both ends, write to an unused address
  task automatic test_register_extremes();
    logic [31:0] t0;
    t0 = 32'h1000_0000;
    write_reg(REG_SEQ_LEN, 0);
    write_reg(REG_KEY0, 32'({DEV_LIGHT, 12'd0}));
    write_reg(REG_HOLDOFF, 0);
    write_reg(REG_LIGHT_MIN, 0);
    send_poll(mk_poll(32'd10, 12'd1, MOVE_NONE, 1'b0, 1'b0));
    send_poll(mk_poll(32'd10, 12'd0, MOVE_LEFT, 1'b1, 1'b0));
    send_poll(mk_poll(32'd11, 12'd4095, MOVE_NONE, 1'b0, 1'b1));
    drain_results();
    write_reg(REG_SEQ_LEN, 7);
    write_reg(REG_KEY0, 32'({DEV_BUTTON, 12'd0}));
    write_reg(REG_KEY1, 32'({DEV_ENCODER, 12'd1}));
    write_reg(REG_KEY2, 32'({DEV_LIGHT, 12'hFFF}));
    write_reg(REG_KEY3, 32'({DEV_ENCODER, 12'd2}));
    write_reg(REG_HOLDOFF, 32'hFFFF);
    write_reg(REG_LIGHT_MIN, 32'd4094);
    send_poll(mk_poll(t0, 12'd0, MOVE_NONE, 1'b1, 1'b0));
    send_poll(mk_poll(t0 + 32'd65535, 12'd0, MOVE_LEFT, 1'b0, 1'b0));
    send_poll(mk_poll(t0 + 32'd131070, 12'd4095, MOVE_NONE, 1'b0, 1'b0));
    send_poll(mk_poll(t0 + 32'd196605, 12'd0, MOVE_RIGHT, 1'b0, 1'b0));
    send_poll(mk_poll(t0 + 32'd196615, 12'd0, MOVE_NONE, 1'b0, 1'b1));
    drain_results();
    // position is at the fourth key, now past the end
    write_reg(REG_SEQ_LEN, 2);
    send_poll(mk_poll(t0 + 32'd196700, 12'd0, MOVE_NONE, 1'b0, 1'b0));
    drain_results();
    write_reg(REG_KEY0, 32'({DEV_NONE, 12'd0}));
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_poll(mk_poll(t0 + 32'd300000, 12'd4095, MOVE_RIGHT, 1'b1, 1'b0));
    drain_results();
    write_reg(REG_LIGHT_MIN, 32'hFFF);
    write_reg(REG_KEY0, 32'({DEV_LIGHT, 12'd0}));
    send_poll(mk_poll(t0 + 32'd400000, 12'd4095, MOVE_NONE, 1'b0, 1'b0));
    drain_results();
    stamp = t0 + 32'd400000;
  endtask

  // receiver holds off while requests keep coming, then sender waits for every result
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    cfg_randomize();
    -> rx_hold_ev;
    repeat (40) send_poll(next_poll($urandom_range(0, 3) != 0));
    drain_results();
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int count);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        drain_results();
        cfg_randomize();
      end
      send_poll(next_poll($urandom_range(0, 3) != 0));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_backpressure();
    test_random_traffic(0, 0, 310);
    test_random_traffic(52, 0, 310);
    test_random_traffic(0, 52, 310);
    test_random_traffic(7, 7, 310);
    drain_results();
    repeat (6) @(posedge clk);
    $display("covered %0d polls and %0d results (%0d completions) over %0d register writes",
             polls_sent, results_seen, completions_seen, reg_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
